### src/mbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbq_pkg
// Types, codes and band boundaries for the multilevel priority band queue.
// ----------------------------------------------------------------------------
package mbq_pkg;

	localparam int NUM_QUEUES = 3;
	localparam int ENTRY_W    = 28;

	localparam logic [3:0] MAX_PRIO  = 4'd9;
	localparam logic [3:0] BAND0_MAX = 4'd3;
	localparam logic [3:0] BAND1_MAX = 4'd6;

	localparam logic [1:0] QUEUE_0 = 2'd0;
	localparam logic [1:0] QUEUE_1 = 2'd1;
	localparam logic [1:0] QUEUE_2 = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_POP_HEAD = 2'd1,
		OP_POP_MAX  = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_PRIO  = 3'd3,
		ST_BAD_QUEUE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	typedef struct packed {
		logic [3:0]  prio;
		logic [15:0] size;
		logic [7:0]  tag;
	} entry_t;

	function automatic logic [1:0] band_of(logic [3:0] prio);
		logic [1:0] q;
		if (prio <= BAND0_MAX) q = QUEUE_0;
		else if (prio <= BAND1_MAX) q = QUEUE_1;
		else q = QUEUE_2;
		return q;
	endfunction

endpackage

### src/mbq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbq_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

### src/multilevel_priority_band_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_band_queue
// Three banded FIFO queues in one entry RAM with insert, pop-head and
// pop-highest (oldest of greatest priority, gap closed by shifting).
// ----------------------------------------------------------------------------
// insert, operation code 3 and every failed request: done in the cycle after
// the start beat, busy stays low, so one such beat per cycle
// pop on a queue holding n entries: a read sweep over the entry RAM finds the
// entry, then a read/write sweep moves the later entries up; busy through
// both sweeps, done rises in the same cycle that busy falls
// the receiver cannot stall; reset clears the counts, the RAM is not cleared
// ----------------------------------------------------------------------------
module multilevel_priority_band_queue
	import mbq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [3:0]  prio_level,
	input  logic [15:0] job_size,
	input  logic [7:0]  job_tag,
	input  logic [1:0]  queue_select,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  out_prio,
	output logic [15:0] out_size,
	output logic [7:0]  out_tag
);

	localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW        = $clog2(RAM_DEPTH);
	localparam int SW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [AW-1:0] slot_addr(logic [1:0] q, logic [SW-1:0] s);
		return AW'(q) * AW'(QUEUE_DEPTH) + AW'(s);
	endfunction

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q [NUM_QUEUES];
	logic [1:0]      sel_q;
	logic [CW-1:0]   last_q, n_q, ptr_q;
	logic [SW-1:0]   bidx_q, idx_s1, best_idx;
	logic            vld_s1;
	entry_t          best_q, rd_entry, wr_entry, res_entry;
	logic            accept, issue, take, res_ld, cnt_inc, cnt_dec, scan_end;
	status_t         res_status;
	logic [1:0]      band;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic            done_q;
	status_t         status_q;
	entry_t          out_q;

	mbq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign band     = band_of(prio_level);
	assign rd_entry = entry_t'(ram_rdata);
	assign take     = (idx_s1 == '0) || (rd_entry.prio > best_q.prio);
	assign best_idx = take ? idx_s1 : bidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		res_ld     = 1'b0;
		res_status = ST_DONE;
		res_entry  = '0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		scan_end   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = slot_addr(sel_q, idx_s1);
		wr_entry   = rd_entry;
		ram_re     = 1'b0;
		ram_raddr  = slot_addr(sel_q, ptr_q[SW-1:0]);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(operation))
						OP_INSERT: begin
							res_ld = 1'b1;
							if (prio_level > MAX_PRIO) begin
								res_status = ST_BAD_PRIO;
							end else if (cnt_q[band] >= CW'(QUEUE_DEPTH)) begin
								res_status = ST_FULL;
							end else begin
								cnt_inc   = 1'b1;
								ram_we    = 1'b1;
								ram_waddr = slot_addr(band, cnt_q[band][SW-1:0]);
								wr_entry  = '{prio: prio_level, size: job_size, tag: job_tag};
							end
						end
						OP_POP_HEAD, OP_POP_MAX: begin
							if (queue_select >= 2'(NUM_QUEUES)) begin
								res_ld     = 1'b1;
								res_status = ST_BAD_QUEUE;
							end else if (cnt_q[queue_select] == '0) begin
								res_ld     = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								state_d = S_SCAN;
							end
						end
						OP_NONE: begin
							res_ld = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				issue  = (ptr_q <= last_q);
				ram_re = issue;
				if (vld_s1 && (CW'(idx_s1) == last_q)) begin
					scan_end = 1'b1;
					state_d  = S_SHIFT;
				end
			end
			S_SHIFT: begin
				issue  = (ptr_q < n_q);
				ram_re = issue;
				ram_we = vld_s1;
				if (!issue && !vld_s1) begin
					state_d   = S_IDLE;
					res_ld    = 1'b1;
					res_entry = best_q;
					cnt_dec   = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// pipeline and sweep registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		idx_s1 <= (state_q == S_SCAN) ? ptr_q[SW-1:0] : SW'(ptr_q - CW'(1));
		if (accept) begin
			sel_q  <= queue_select;
			n_q    <= cnt_q[queue_select[1:0] == 2'(NUM_QUEUES) ? QUEUE_0 : queue_select];
			last_q <= (op_t'(operation) == OP_POP_HEAD) ? '0 :
				cnt_q[queue_select[1:0] == 2'(NUM_QUEUES) ? QUEUE_0 : queue_select] - CW'(1);
			ptr_q  <= '0;
		end else if (scan_end) begin
			ptr_q <= CW'(best_idx) + CW'(1);
		end else if (issue) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (state_q == S_SCAN && vld_s1 && take) begin
			best_q <= rd_entry;
		end
		if (state_q == S_SCAN && vld_s1) begin
			bidx_q <= best_idx;
		end
	end

	// per-queue fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) cnt_q[i] <= '0;
		end else begin
			if (cnt_inc) cnt_q[band] <= cnt_q[band] + CW'(1);
			if (cnt_dec) cnt_q[sel_q] <= cnt_q[sel_q] - CW'(1);
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= res_ld;
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			status_q <= res_status;
			out_q    <= res_entry;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign out_prio = out_q.prio;
	assign out_size = out_q.size;
	assign out_tag  = out_q.tag;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CW'(QUEUE_DEPTH)) && (cnt_q[1] <= CW'(QUEUE_DEPTH)) &&
		(cnt_q[2] <= CW'(QUEUE_DEPTH)))
		else $error("queue count above depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_bad_prio: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_INSERT && prio_level > MAX_PRIO)
		|=> (done && status == ST_BAD_PRIO && out_prio == '0))
		else $error("bad priority not reported");

	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_POP_HEAD || operation == OP_POP_MAX) &&
		queue_select < 2'(NUM_QUEUES) && cnt_q[queue_select] != '0) |=> (busy && !done))
		else $error("pop did not start a sweep");

endmodule
